/* hw/rtl/cem_pkg.sv */
package cem_pkg;

    // Characters of the expression grammar.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result status codes.
    localparam logic [1:0] ST_NOMATCH = 2'd0;
    localparam logic [1:0] ST_MATCH   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Part sections.
    localparam logic [1:0] SEC_BASE = 2'd0;
    localparam logic [1:0] SEC_END  = 2'd1;
    localparam logic [1:0] SEC_STEP = 2'd2;

    localparam logic [63:0] STEP_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [6:0]  NUM_SAT    = 7'd127;
    localparam logic [2:0]  MOD_LAST   = 3'd5;

    typedef struct packed {
        logic load;
        logic char_step;
        logic pe_start;
        logic mod_step;
        logic pe_fin;
        logic post_comma;
        logic post_field;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic sep_fe;
        logic comma;
        logic in_sep;
        logic last;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [6:0] field_min(input logic [2:0] idx);
        logic [6:0] r;
        case (idx)
            3'd2, 3'd3: r = 7'd1;
            default:    r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] field_max(input logic [2:0] idx);
        logic [6:0] r;
        case (idx)
            3'd0:    r = 7'd59;
            3'd1:    r = 7'd23;
            3'd2:    r = 7'd31;
            3'd3:    r = 7'd12;
            default: r = 7'd6;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] sat_acc(input logic [6:0] n, input logic [3:0] d);
        logic [10:0] r;
        r = {1'b0, n, 3'b000} + {3'b000, n, 1'b0} + {7'd0, d};
        return (r > 11'(NUM_SAT)) ? NUM_SAT : r[6:0];
    endfunction

endpackage

/* hw/rtl/cem_ctrl.sv */
module cem_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cem_pkg::t_dp_stat i_stat,
    output cem_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHAR  = 3'd1;
    localparam logic [2:0] S_PE    = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_PEFIN = 3'd4;
    localparam logic [2:0] S_POST  = 3'd5;
    localparam logic [2:0] S_LAST  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_post, n_post;   // 1: close the field, 0: close the part only

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_post  = r_post;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHAR;
            end
            S_CHAR: begin
                if (i_stat.sep_fe) begin
                    n_post  = 1'b1;
                    n_state = S_PE;
                end else if (i_stat.comma) begin
                    n_post  = 1'b0;
                    n_state = S_PE;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_PE: begin
                n_cnt   = 3'd0;
                n_state = S_MOD;
            end
            S_MOD: begin
                if (r_cnt == cem_pkg::MOD_LAST) n_state = S_PEFIN;
                else n_cnt = r_cnt + 3'd1;
            end
            S_PEFIN: n_state = S_POST;
            S_POST:  n_state = S_LAST;
            S_LAST: begin
                if (i_stat.last && !i_stat.in_sep) begin
                    n_post  = 1'b1;
                    n_state = S_PE;
                end else if (i_stat.last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
            r_post  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_post  <= n_post;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.char_step  = (r_state == S_CHAR);
        o_cmd.pe_start   = (r_state == S_PE);
        o_cmd.mod_step   = (r_state == S_MOD);
        o_cmd.pe_fin     = (r_state == S_PEFIN);
        o_cmd.post_comma = (r_state == S_POST) && !r_post;
        o_cmd.post_field = (r_state == S_POST) && r_post;
        o_cmd.emit       = (r_state == S_EMIT) && !i_stat.out_busy;
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_mod_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_cnt <= cem_pkg::MOD_LAST))
        else $error("remainder step counter overran");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after a result");

endmodule

/* hw/rtl/cem_datapath.sv */
module cem_datapath #(
    parameter int MAX_LENGTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cem_pkg::t_dp_cmd  i_cmd,
    output cem_pkg::t_dp_stat o_stat,
    input  logic [31:0]       i_in_data,
    input  logic              i_in_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_out_status
);

    localparam int         CW      = $clog2(MAX_LENGTH + 1);
    localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LENGTH);

    // Input item
    logic [7:0] r_char;
    logic       r_last;
    logic [5:0] r_minute;
    logic [4:0] r_hour;
    logic [4:0] r_dom;
    logic [3:0] r_month;
    logic [2:0] r_wday;

    // Parse state
    logic [2:0]    r_fn, n_fn;
    logic [CW-1:0] r_cc, n_cc;
    logic          r_in_sep, n_in_sep;
    logic [1:0]    r_sec, n_sec;
    logic [6:0]    r_rstart, n_rstart;
    logic [6:0]    r_rend, n_rend;
    logic [63:0]   r_step, n_step;
    logic          r_f_star, n_f_star;
    logic          r_f_d0, n_f_d0;
    logic          r_f_d1, n_f_d1;
    logic          r_f_d2, n_f_d2;
    logic          r_f_ovf, n_f_ovf;
    logic          r_f_dash, n_f_dash;
    logic          r_f_fstar, n_f_fstar;
    logic [6:0]    r_flen, n_flen;
    logic          r_fhit, n_fhit;
    logic [4:0]    r_hit, n_hit;
    logic [1:0]    r_star, n_star;
    logic          r_bad, n_bad;

    // Remainder unit
    logic       r_run, n_run;
    logic [5:0] r_rem, n_rem;
    logic [5:0] r_div, n_div;
    logic [5:0] r_mdiv, n_mdiv;

    // Result register
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_out_status, n_out_status;

    logic        is_sep, is_digit, fn_ok, guard, e_any, in_rng;
    logic [2:0]  idx;
    logic [3:0]  dig;
    logic [5:0]  cur_v;
    logic [6:0]  fmin, fmax, first, last_v, diff7;
    logic [63:0] step_eff;
    logic [67:0] step10;
    logic [6:0]  rem_t;
    logic        dm, wd, comb_hit;

    assign is_sep   = (r_char == cem_pkg::CH_SPACE) || (r_char == cem_pkg::CH_TAB);
    assign is_digit = (r_char >= cem_pkg::CH_ZERO) && (r_char <= cem_pkg::CH_NINE);
    assign dig      = r_char[3:0];
    assign fn_ok    = (r_fn >= 3'd1) && (r_fn <= 3'd5);
    assign idx      = r_fn - 3'd1;
    assign fmin     = cem_pkg::field_min(idx);
    assign fmax     = cem_pkg::field_max(idx);
    assign step10   = {r_step, 3'b000} + {3'b000, r_step, 1'b0} + {64'd0, dig};
    assign rem_t    = {r_rem, r_div[5]};

    always_comb begin
        case (idx)
            3'd0:    cur_v = r_minute;
            3'd1:    cur_v = {1'b0, r_hour};
            3'd2:    cur_v = {1'b0, r_dom};
            3'd3:    cur_v = {2'b00, r_month};
            default: cur_v = {3'b000, r_wday};
        endcase
    end

    always_comb begin
        guard    = !r_fhit && !r_bad && fn_ok;
        e_any    = !(r_f_star || r_f_d0) || (r_f_dash && !r_f_d1) ||
                   ((r_sec == cem_pkg::SEC_STEP) && (!r_f_d2 || r_f_ovf || (r_step == 64'd0)));
        if (r_f_star) begin
            first  = fmin;
            last_v = fmax;
        end else if (r_f_dash) begin
            first  = r_rstart;
            last_v = r_rend;
        end else begin
            first  = r_rstart;
            last_v = r_rstart;
        end
        e_any    = e_any || (first < fmin) || (last_v > fmax) || (first > last_v);
        in_rng   = ({1'b0, cur_v} >= first) && ({1'b0, cur_v} <= last_v);
        diff7    = {1'b0, cur_v} - first;
        step_eff = (r_sec == cem_pkg::SEC_STEP) ? r_step : 64'd1;
    end

    assign o_stat.sep_fe   = is_sep && !r_in_sep;
    assign o_stat.comma    = !is_sep && (r_char == cem_pkg::CH_COMMA) &&
                             (r_in_sep ? (r_fn < 3'd5) : (!r_fhit && fn_ok));
    assign o_stat.in_sep   = r_in_sep;
    assign o_stat.last     = r_last;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign dm       = r_hit[2];
    assign wd       = r_hit[4];
    assign comb_hit = (r_star == 2'b00) ? (dm | wd) : (dm & wd);

    always_comb begin
        n_fn = r_fn;   n_cc = r_cc;   n_in_sep = r_in_sep;  n_sec = r_sec;
        n_rstart = r_rstart;  n_rend = r_rend;  n_step = r_step;
        n_f_star = r_f_star;  n_f_d0 = r_f_d0;  n_f_d1 = r_f_d1;  n_f_d2 = r_f_d2;
        n_f_ovf = r_f_ovf;    n_f_dash = r_f_dash;  n_f_fstar = r_f_fstar;
        n_flen = r_flen;  n_fhit = r_fhit;  n_hit = r_hit;  n_star = r_star;
        n_bad = r_bad;
        n_run = r_run;  n_rem = r_rem;  n_div = r_div;  n_mdiv = r_mdiv;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;

        if (i_cmd.char_step) begin
            if (r_cc < LEN_MAX) n_cc = r_cc + CW'(1);
            if (n_cc >= LEN_MAX) n_bad = 1'b1;
            if (!is_sep) begin
                if (r_in_sep) begin
                    n_in_sep = 1'b0;
                    if (r_fn < 3'd6) n_fn = r_fn + 3'd1;
                    n_fhit = 1'b0;  n_flen = 7'd0;
                    n_f_star = 1'b0; n_f_d0 = 1'b0; n_f_d1 = 1'b0; n_f_d2 = 1'b0;
                    n_f_ovf = 1'b0;  n_f_dash = 1'b0; n_f_fstar = 1'b0;
                    n_sec = cem_pkg::SEC_BASE;
                    n_rstart = 7'd0; n_rend = 7'd0; n_step = 64'd0;
                end
                if (n_fn > 3'd5) begin
                    n_bad = 1'b1;
                end else begin
                    if (n_flen < cem_pkg::NUM_SAT) n_flen = n_flen + 7'd1;
                    if ((n_flen == 7'd1) && (r_char == cem_pkg::CH_STAR)) n_f_fstar = 1'b1;
                    // A comma closes the part, which the controller runs separately.
                    if (!n_fhit && (r_char != cem_pkg::CH_COMMA)) begin
                        if (r_char == cem_pkg::CH_SLASH) begin
                            if (n_sec == cem_pkg::SEC_STEP) n_bad = 1'b1;
                            else n_sec = cem_pkg::SEC_STEP;
                        end else if (r_char == cem_pkg::CH_DASH) begin
                            if ((n_sec != cem_pkg::SEC_BASE) || n_f_star) n_bad = 1'b1;
                            else begin
                                n_sec    = cem_pkg::SEC_END;
                                n_f_dash = 1'b1;
                            end
                        end else if (r_char == cem_pkg::CH_STAR) begin
                            if ((n_sec != cem_pkg::SEC_BASE) || n_f_star || n_f_d0) n_bad = 1'b1;
                            else n_f_star = 1'b1;
                        end else if (is_digit) begin
                            if (n_sec == cem_pkg::SEC_BASE) begin
                                if (n_f_star) n_bad = 1'b1;
                                else begin
                                    n_rstart = cem_pkg::sat_acc(n_rstart, dig);
                                    n_f_d0   = 1'b1;
                                end
                            end else if (n_sec == cem_pkg::SEC_END) begin
                                n_rend = cem_pkg::sat_acc(n_rend, dig);
                                n_f_d1 = 1'b1;
                            end else begin
                                // The step register is still r_step here: a new field
                                // cannot already be in the step section.
                                if (step10 > {4'd0, cem_pkg::STEP_LIMIT}) n_f_ovf = 1'b1;
                                else n_step = step10[63:0];
                                n_f_d2 = 1'b1;
                            end
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                end
            end
        end

        if (i_cmd.pe_start) begin
            n_run = 1'b0;
            if (guard) begin
                if (e_any) begin
                    n_bad = 1'b1;
                end else if (in_rng) begin
                    if (step_eff >= 64'd64) begin
                        // The difference is below 64, so only zero divides evenly.
                        if (diff7 == 7'd0) n_fhit = 1'b1;
                    end else begin
                        n_run  = 1'b1;
                        n_rem  = 6'd0;
                        n_div  = diff7[5:0];
                        n_mdiv = step_eff[5:0];
                    end
                end
            end
        end

        if (i_cmd.mod_step) begin
            if (rem_t >= {1'b0, r_mdiv}) n_rem = 6'(rem_t - {1'b0, r_mdiv});
            else n_rem = rem_t[5:0];
            n_div = {r_div[4:0], 1'b0};
        end

        if (i_cmd.pe_fin) begin
            if (r_run && (r_rem == 6'd0)) n_fhit = 1'b1;
            n_run = 1'b0;
        end

        if (i_cmd.post_comma) begin
            n_sec = cem_pkg::SEC_BASE;
            n_rstart = 7'd0; n_rend = 7'd0; n_step = 64'd0;
            n_f_star = 1'b0; n_f_d0 = 1'b0; n_f_d1 = 1'b0; n_f_d2 = 1'b0;
            n_f_ovf = 1'b0;  n_f_dash = 1'b0;
        end

        if (i_cmd.post_field) begin
            if (fn_ok) begin
                if (r_fhit) n_hit[idx] = 1'b1;
                if ((r_flen == 7'd1) && r_f_fstar) begin
                    if (idx == 3'd2) n_star[0] = 1'b1;
                    if (idx == 3'd4) n_star[1] = 1'b1;
                end
            end
            n_in_sep = 1'b1;
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            if (r_bad || (r_fn != 3'd5)) n_out_status = cem_pkg::ST_INVALID;
            else if ((r_hit & 5'b01011) != 5'b01011) n_out_status = cem_pkg::ST_NOMATCH;
            else if (comb_hit) n_out_status = cem_pkg::ST_MATCH;
            else n_out_status = cem_pkg::ST_NOMATCH;
            n_fn = 3'd0;  n_cc = '0;  n_in_sep = 1'b1;  n_sec = cem_pkg::SEC_BASE;
            n_rstart = 7'd0;  n_rend = 7'd0;  n_step = 64'd0;
            n_f_star = 1'b0; n_f_d0 = 1'b0; n_f_d1 = 1'b0; n_f_d2 = 1'b0;
            n_f_ovf = 1'b0;  n_f_dash = 1'b0; n_f_fstar = 1'b0;
            n_flen = 7'd0;  n_fhit = 1'b0;  n_hit = 5'd0;  n_star = 2'd0;  n_bad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char   <= i_in_data[7:0];
            r_minute <= i_in_data[13:8];
            r_hour   <= i_in_data[18:14];
            r_dom    <= i_in_data[23:19];
            r_month  <= i_in_data[27:24];
            r_wday   <= i_in_data[30:28];
            r_last   <= i_in_last;
        end
        r_rstart <= n_rstart;
        r_rend   <= n_rend;
        r_step   <= n_step;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_mdiv   <= n_mdiv;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn <= 3'd0;  r_cc <= '0;  r_in_sep <= 1'b1;  r_sec <= cem_pkg::SEC_BASE;
            r_f_star <= 1'b0; r_f_d0 <= 1'b0; r_f_d1 <= 1'b0; r_f_d2 <= 1'b0;
            r_f_ovf <= 1'b0;  r_f_dash <= 1'b0; r_f_fstar <= 1'b0;
            r_flen <= 7'd0;  r_fhit <= 1'b0;  r_hit <= 5'd0;  r_star <= 2'd0;
            r_bad <= 1'b0;   r_run <= 1'b0;   r_out_valid <= 1'b0;
        end else begin
            r_fn <= n_fn;  r_cc <= n_cc;  r_in_sep <= n_in_sep;  r_sec <= n_sec;
            r_f_star <= n_f_star; r_f_d0 <= n_f_d0; r_f_d1 <= n_f_d1; r_f_d2 <= n_f_d2;
            r_f_ovf <= n_f_ovf;   r_f_dash <= n_f_dash; r_f_fstar <= n_f_fstar;
            r_flen <= n_flen;  r_fhit <= n_fhit;  r_hit <= n_hit;  r_star <= n_star;
            r_bad <= n_bad;    r_run <= n_run;    r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;

endmodule

/* hw/rtl/cron_expression_matcher.sv */
// One character per input transfer. A plain character passes the load,
// character and last-check states before the next can be accepted; a
// character that closes a part or a field also runs the 6-step remainder
// unit, the final one possibly twice before it waits for the output register.
// Synchronous active-low reset returns the parser to the start of an expression.
module cron_expression_matcher #(
    parameter int MAX_LENGTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] expr_char, [13:8] minute, [18:14] hour, [23:19] day_of_month,
    // [27:24] month_number, [30:28] weekday, [31] zero
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [7:2] zero
    output logic [7:0]  m_axis_tdata
);

    cem_pkg::t_dp_cmd  cmd;
    cem_pkg::t_dp_stat stat;
    logic [1:0]        status;

    cem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cem_datapath #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (status)
    );

    assign m_axis_tdata = {6'd0, status};

endmodule
